FILE: src/ptrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrm_pkg
// Shared types and constants of the page table range mapper: request and
// result records, command codes, status codes, and the control and status
// records between controller and datapath.
// ----------------------------------------------------------------------------
package ptrm_pkg;

	localparam int TABLE_ENTRIES_DEF = 512;

	localparam int ENTRY_W  = 64;
	localparam int VADDR_W  = 48;
	localparam int PADDR_W  = 52;
	localparam int SIZE_W   = 32;
	localparam int EIDX_W   = 9;
	localparam int STATUS_W = 2;
	localparam int CMD_W    = 2;

	localparam int SHIFT_SMALL = 12;
	localparam int SHIFT_LARGE = 21;
	localparam int PAGES_W     = SIZE_W + 1 - SHIFT_SMALL;

	localparam int CFG_IDX_W = 2;

	localparam logic [CMD_W-1:0] CMD_MAP    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_VIRT_BASE_SMALL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VIRT_BASE_LARGE = 2'd1;

	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOROOM = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FAULT  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [PADDR_W-1:0] phys_addr;
		logic [SIZE_W-1:0]  range_size;
		logic               large_page;
		logic               writable;
		logic               write_back;
		logic [VADDR_W-1:0] linear_addr;
		logic [EIDX_W-1:0]  entry_index;
	} req_t;

	typedef struct packed {
		logic [VADDR_W-1:0]  virt_addr;
		logic [ENTRY_W-1:0]  entry_value;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef enum logic [2:0] {
		RESP_OK     = 3'd0,
		RESP_NOROOM = 3'd1,
		RESP_FAULT  = 3'd2,
		RESP_VA     = 3'd3,
		RESP_ENTRY  = 3'd4
	} resp_kind_t;

	typedef struct packed {
		logic       load;
		logic       clr;
		logic       eval;
		logic       remove;
		logic       map_start;
		logic       map_step;
		logic       resp_en;
		resp_kind_t resp_kind;
	} ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             clr_last;
		logic             fits;
		logic             pages_zero;
		logic             map_fault;
		logic             map_last;
	} sts_t;

endpackage

FILE: src/ptrm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrm_dp
// Datapath: request latch, base registers, both page tables, bump indexes,
// page count and address arithmetic, entry builder and result register.
// ----------------------------------------------------------------------------
module ptrm_dp import ptrm_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  req_t                 req,
	input  ctl_t                 ctl,
	output sts_t                 sts,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VADDR_W-1:0]   cfg_data,
	output logic                 done,
	output rsp_t                 rsp
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int NW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [PADDR_W-1:0] PSIZE_SMALL = PADDR_W'(1) << SHIFT_SMALL;
	localparam logic [PADDR_W-1:0] PSIZE_LARGE = PADDR_W'(1) << SHIFT_LARGE;

	logic [ENTRY_W-1:0] small_mem [TABLE_ENTRIES];
	logic [ENTRY_W-1:0] large_mem [TABLE_ENTRIES];

	req_t               req_q;
	logic [VADDR_W-1:0] vbase_small_q;
	logic [VADDR_W-1:0] vbase_large_q;
	logic [NW-1:0]      next_small_q;
	logic [NW-1:0]      next_large_q;
	logic [IW-1:0]      clr_ptr_q;
	logic [PAGES_W-1:0] pages_q;
	logic [VADDR_W-1:0] va_q;
	logic [IW-1:0]      rd_ptr_q;
	logic [NW-1:0]      rem_q;
	logic               chk_q;
	logic [IW-1:0]      chk_addr_q;
	logic [PADDR_W-1:0] base_q;
	logic [ENTRY_W-1:0] rd_small_q;
	logic [ENTRY_W-1:0] rd_large_q;
	logic               done_q;
	rsp_t               rsp_q;

	logic [NW-1:0]      next_sel;
	logic [SIZE_W:0]    sum_small;
	logic [SIZE_W:0]    sum_large;
	logic [PAGES_W-1:0] pages;
	logic [VADDR_W-1:0] va;
	logic [PAGES_W:0]   need;
	logic [EIDX_W-1:0]  rm_idx;
	logic               rm_ok;
	logic               rd_ok;
	logic [ENTRY_W-1:0] rdata;
	logic               nonzero;
	logic               map_we;
	logic [ENTRY_W-1:0] entry;
	logic [IW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic               wr_any;
	logic               we_small;
	logic               we_large;
	logic [IW-1:0]      rd_addr;

	assign next_sel = req_q.large_page ? next_large_q : next_small_q;

	assign sum_small = (SIZE_W+1)'(req_q.range_size) + (SIZE_W+1)'(req_q.phys_addr[11:0])
		+ (SIZE_W+1)'(PSIZE_SMALL - 1);
	assign sum_large = (SIZE_W+1)'(req_q.range_size) + (SIZE_W+1)'(req_q.phys_addr[20:0])
		+ (SIZE_W+1)'(PSIZE_LARGE - 1);
	assign pages = req_q.large_page ? PAGES_W'(sum_large[SIZE_W:SHIFT_LARGE])
		: PAGES_W'(sum_small[SIZE_W:SHIFT_SMALL]);

	assign va = (req_q.large_page ? vbase_large_q : vbase_small_q)
		+ (req_q.large_page ? VADDR_W'({next_sel, req_q.phys_addr[20:0]})
		: VADDR_W'({next_sel, req_q.phys_addr[11:0]}));

	assign need = (PAGES_W+1)'(next_sel) + (PAGES_W+1)'(pages_q);

	assign rm_idx = req_q.large_page ? req_q.linear_addr[29:21] : req_q.linear_addr[20:12];
	assign rm_ok  = 32'(rm_idx) < TABLE_ENTRIES;
	assign rd_ok  = 32'(req_q.entry_index) < TABLE_ENTRIES;

	assign rdata   = req_q.large_page ? rd_large_q : rd_small_q;
	assign nonzero = |rdata;
	assign map_we  = ctl.map_step & chk_q & ~nonzero;

	always_comb begin
		entry        = ENTRY_W'(base_q);
		entry[0]     = 1'b1;
		entry[1]     = req_q.writable;
		entry[3]     = ~req_q.write_back;
		entry[4]     = ~req_q.write_back;
		entry[5]     = 1'b1;
		entry[6]     = 1'b1;
		entry[7]     = req_q.large_page | ~req_q.write_back;
		entry[12]    = base_q[12] | (req_q.large_page & ~req_q.write_back);
	end

	assign wr_addr  = ctl.clr ? clr_ptr_q : (ctl.remove ? rm_idx[IW-1:0] : chk_addr_q);
	assign wr_data  = (ctl.clr | ctl.remove) ? '0 : entry;
	assign wr_any   = (ctl.remove & rm_ok) | map_we;
	assign we_small = ctl.clr | (~req_q.large_page & wr_any);
	assign we_large = ctl.clr | (req_q.large_page & wr_any);
	assign rd_addr  = ctl.map_step ? rd_ptr_q : req_q.entry_index[IW-1:0];

	always_ff @(posedge clk) begin
		if (we_small) begin
			small_mem[wr_addr] <= wr_data;
		end
		rd_small_q <= small_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (we_large) begin
			large_mem[wr_addr] <= wr_data;
		end
		rd_large_q <= large_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbase_small_q <= '0;
			vbase_large_q <= '0;
			next_small_q  <= '0;
			next_large_q  <= '0;
			clr_ptr_q     <= '0;
			rem_q         <= '0;
			chk_q         <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			done_q <= ctl.resp_en;
			if (cfg_we && cfg_index == REG_VIRT_BASE_SMALL) begin
				vbase_small_q <= cfg_data;
			end
			if (cfg_we && cfg_index == REG_VIRT_BASE_LARGE) begin
				vbase_large_q <= cfg_data;
			end
			if (ctl.clr) begin
				clr_ptr_q <= clr_ptr_q + IW'(1);
			end
			if (ctl.map_start) begin
				rem_q <= pages_q[NW-1:0];
				chk_q <= 1'b0;
			end else if (ctl.map_step) begin
				if (rem_q != '0) begin
					rem_q <= rem_q - NW'(1);
					chk_q <= 1'b1;
				end else begin
					chk_q <= 1'b0;
				end
			end
			if (map_we) begin
				if (req_q.large_page) begin
					next_large_q <= NW'(chk_addr_q) + NW'(1);
				end else begin
					next_small_q <= NW'(chk_addr_q) + NW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q <= req;
		end
		if (ctl.eval) begin
			pages_q <= pages;
			va_q    <= va;
		end
		if (ctl.map_start) begin
			rd_ptr_q <= next_sel[IW-1:0];
			base_q   <= req_q.large_page
				? {req_q.phys_addr[PADDR_W-1:SHIFT_LARGE], SHIFT_LARGE'(0)}
				: {req_q.phys_addr[PADDR_W-1:SHIFT_SMALL], SHIFT_SMALL'(0)};
		end else if (ctl.map_step) begin
			if (rem_q != '0) begin
				rd_ptr_q   <= rd_ptr_q + IW'(1);
				chk_addr_q <= rd_ptr_q;
			end
			if (map_we) begin
				base_q <= base_q + (req_q.large_page ? PSIZE_LARGE : PSIZE_SMALL);
			end
		end
		if (ctl.resp_en) begin
			rsp_q <= '0;
			case (ctl.resp_kind)
				RESP_NOROOM: rsp_q.status <= STATUS_NOROOM;
				RESP_FAULT:  rsp_q.status <= STATUS_FAULT;
				RESP_VA:     rsp_q.virt_addr <= va_q;
				RESP_ENTRY:  rsp_q.entry_value <= rd_ok ? rdata : '0;
				default:     rsp_q.status <= STATUS_OK;
			endcase
		end
	end

	assign sts.cmd        = req_q.cmd;
	assign sts.clr_last   = clr_ptr_q == IW'(TABLE_ENTRIES - 1);
	assign sts.fits       = need <= (PAGES_W+1)'(TABLE_ENTRIES);
	assign sts.pages_zero = pages_q == '0;
	assign sts.map_fault  = chk_q & nonzero;
	assign sts.map_last   = chk_q & ~nonzero & (rem_q == '0);

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: src/ptrm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrm_ctrl
// Controller: clearing pass after reset, command decode, map loop sequencing,
// halt flag and result issue.
// ----------------------------------------------------------------------------
module ptrm_ctrl import ptrm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sts_t sts,
	output ctl_t ctl
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_EVAL  = 6'b000100,
		ST_CHECK = 6'b001000,
		ST_MAP   = 6'b010000,
		ST_READ  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   halted_q;
	logic   halt_set;

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		halt_set  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ctl.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				ctl.eval = 1'b1;
				if (halted_q) begin
					ctl.resp_en   = 1'b1;
					ctl.resp_kind = RESP_FAULT;
					state_d       = ST_IDLE;
				end else begin
					case (sts.cmd)
						CMD_MAP: state_d = ST_CHECK;
						CMD_READ: state_d = ST_READ;
						CMD_REMOVE: begin
							ctl.remove    = 1'b1;
							ctl.resp_en   = 1'b1;
							ctl.resp_kind = RESP_OK;
							state_d       = ST_IDLE;
						end
						default: begin
							ctl.resp_en   = 1'b1;
							ctl.resp_kind = RESP_OK;
							state_d       = ST_IDLE;
						end
					endcase
				end
			end
			ST_CHECK: begin
				if (!sts.fits) begin
					ctl.resp_en   = 1'b1;
					ctl.resp_kind = RESP_NOROOM;
					state_d       = ST_IDLE;
				end else if (sts.pages_zero) begin
					ctl.resp_en   = 1'b1;
					ctl.resp_kind = RESP_VA;
					state_d       = ST_IDLE;
				end else begin
					ctl.map_start = 1'b1;
					state_d       = ST_MAP;
				end
			end
			ST_MAP: begin
				ctl.map_step = 1'b1;
				if (sts.map_fault) begin
					halt_set      = 1'b1;
					ctl.resp_en   = 1'b1;
					ctl.resp_kind = RESP_FAULT;
					state_d       = ST_IDLE;
				end else if (sts.map_last) begin
					ctl.resp_en   = 1'b1;
					ctl.resp_kind = RESP_VA;
					state_d       = ST_IDLE;
				end
			end
			ST_READ: begin
				ctl.resp_en   = 1'b1;
				ctl.resp_kind = RESP_ENTRY;
				state_d       = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			halted_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (halt_set) begin
				halted_q <= 1'b1;
			end
		end
	end

	assign busy = state_q != ST_IDLE;

endmodule

FILE: src/page_table_range_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_range_mapper
// Two leaf page tables (4 KB and 2 MB entries) with bump allocation: maps a
// physical range into consecutive entries, removes and reads single entries.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------
//   request  | start, busy            | req (cmd, addresses, flags, index)
//   result   | done (one-cycle pulse) | rsp (virt_addr, entry_value, status)
//   config   | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// A request goes through EVAL; remove, halted and unused commands end there, a read
// adds READ, and a map adds CHECK and, if it fits and covers a page, the MAP loop.
// The map loop writes one entry per cycle, one table read ahead of the write.
// After reset a clearing pass over every entry of both tables holds busy high;
// configuration writes are taken at any time. Results cannot be stalled.
// ----------------------------------------------------------------------------
module page_table_range_mapper import ptrm_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  req_t                 req,
	output logic                 done,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VADDR_W-1:0]   cfg_data
);

	ctl_t ctl;
	sts_t sts;

	assign cfg_ready = 1'b1;

	ptrm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl)
	);

	ptrm_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ctl       (ctl),
		.sts       (sts),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.rsp       (rsp)
	);

endmodule

FILE: tb/page_table_range_mapper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_range_mapper_tb
// Self-checking bench for the page table range mapper. A queue-fed driver
// issues map, remove, read and unused commands with random gaps; a monitor
// runs each accepted request through an in-bench model of both leaf tables
// and bump indexes and checks every result field against it. Base address
// registers are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module page_table_range_mapper_tb;
	import ptrm_pkg::*;

	localparam int NENT        = TABLE_ENTRIES_DEF;
	localparam int HALF_PERIOD = 10;
	localparam int IDLE_PCT    = 12;
	localparam int STALL_LIMIT = 8000;
	localparam int TAIL_CYCLES = 20;
	localparam int RAND_ITEMS  = 100;
	localparam int PSZ_SMALL   = 1 << SHIFT_SMALL;
	localparam int PSZ_LARGE   = 1 << SHIFT_LARGE;

	localparam logic [CMD_W-1:0]     CMD_NONE    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam logic [VADDR_W-1:0]   VA_MAX      = '1;
	localparam logic [PADDR_W-1:0]   PA_MAX      = '1;
	localparam logic [SIZE_W-1:0]    SIZE_MAX    = '1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	req_t                 req = '0;
	logic                 done;
	rsp_t                 rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VADDR_W-1:0]   cfg_data = '0;

	logic [ENTRY_W-1:0] leaf_tbl [2][NENT];
	int unsigned        bump_idx [2];
	logic [VADDR_W-1:0] vbase [2];
	bit                 halted_pred;

	rsp_t        pending_rsp [$];
	req_t        todo_req [$];
	int unsigned queued_cnt = 0;
	int unsigned accepted_cnt = 0;
	int unsigned issued_cnt = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned stall_cnt = 0;
	logic        req_taken = 1'b0;

	page_table_range_mapper u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic logic [ENTRY_W-1:0] leaf_entry(logic [PADDR_W-1:0] base, bit big_page,
		bit wr, bit wb);
		logic [ENTRY_W-1:0] e;
		e = ENTRY_W'(base);
		e[0] = 1'b1;
		e[5] = 1'b1;
		e[6] = 1'b1;
		if (wr) e[1] = 1'b1;
		if (big_page) e[7] = 1'b1;
		if (!wb) begin
			e[4:3] = 2'b11;
			if (big_page) e[12] = 1'b1;
			else e[7] = 1'b1;
		end
		return e;
	endfunction

	function automatic rsp_t apply_request(req_t r);
		rsp_t               o;
		bit                 sel;
		int unsigned        shift;
		logic [63:0]        psize;
		logic [63:0]        offset;
		logic [63:0]        pages;
		logic [63:0]        k;
		logic [PADDR_W-1:0] base;
		logic [EIDX_W-1:0]  idx;
		o = '0;
		sel = r.large_page;
		shift = sel ? SHIFT_LARGE : SHIFT_SMALL;
		if (halted_pred) begin
			o.status = STATUS_FAULT;
			return o;
		end
		case (r.cmd)
			CMD_MAP: begin
				psize = 64'd1 << shift;
				offset = 64'(r.phys_addr) & (psize - 64'd1);
				base = r.phys_addr & ~PADDR_W'(psize - 64'd1);
				pages = (offset + 64'(r.range_size) + psize - 64'd1) >> shift;
				if (64'(bump_idx[sel]) + pages > NENT) begin
					o.status = STATUS_NOROOM;
				end else begin
					o.virt_addr = VADDR_W'(64'(vbase[sel]) + (64'(bump_idx[sel]) << shift) + offset);
					for (k = 0; k < pages && o.status == STATUS_OK; k++) begin
						if (leaf_tbl[sel][bump_idx[sel]] != '0) begin
							halted_pred = 1'b1;
							o.status = STATUS_FAULT;
							o.virt_addr = '0;
						end else begin
							leaf_tbl[sel][bump_idx[sel]] = leaf_entry(base, sel, r.writable,
								r.write_back);
							bump_idx[sel]++;
							base = base + PADDR_W'(psize);
						end
					end
				end
			end
			CMD_REMOVE: begin
				idx = EIDX_W'(r.linear_addr >> shift);
				leaf_tbl[sel][idx] = '0;
			end
			CMD_READ: o.entry_value = leaf_tbl[sel][r.entry_index];
			default: ;
		endcase
		return o;
	endfunction

	function automatic req_t blank_req(logic [CMD_W-1:0] cmd, bit big_page);
		req_t r;
		r.cmd = cmd;
		r.phys_addr = PADDR_W'({$urandom, $urandom});
		r.range_size = $urandom;
		r.large_page = big_page;
		r.writable = 1'($urandom);
		r.write_back = 1'($urandom);
		r.linear_addr = VADDR_W'({$urandom, $urandom});
		r.entry_index = EIDX_W'($urandom);
		return r;
	endfunction

	function automatic req_t map_req(logic [PADDR_W-1:0] phys, logic [SIZE_W-1:0] size,
		bit big_page, bit wr, bit wb);
		req_t r;
		r = blank_req(CMD_MAP, big_page);
		r.phys_addr = phys;
		r.range_size = size;
		r.writable = wr;
		r.write_back = wb;
		return r;
	endfunction

	function automatic req_t entry_req(logic [CMD_W-1:0] cmd, bit big_page, int unsigned idx);
		req_t r;
		r = blank_req(cmd, big_page);
		r.entry_index = EIDX_W'(idx);
		if (big_page) r.linear_addr[SHIFT_LARGE +: EIDX_W] = EIDX_W'(idx);
		else r.linear_addr[SHIFT_SMALL +: EIDX_W] = EIDX_W'(idx);
		return r;
	endfunction

	function automatic req_t random_req();
		req_t        r;
		int unsigned pick;
		int unsigned psz;
		int unsigned near;
		bit          big_page;
		big_page = 1'($urandom);
		pick = $urandom_range(99);
		psz = big_page ? PSZ_LARGE : PSZ_SMALL;
		near = bump_idx[big_page] + 8 > NENT - 1 ? NENT - 1 : bump_idx[big_page] + 8;
		if (pick < 45) begin
			r = blank_req(CMD_MAP, big_page);
			if ($urandom_range(4) == 0) r.phys_addr[SHIFT_LARGE-1:0] = '0;
			pick = $urandom_range(9);
			if (pick < 7) r.range_size = $urandom_range(3 * psz);
			else if (pick < 9) r.range_size = $urandom_range(24 * psz);
		end else if (pick < 95) begin
			r = entry_req(pick < 65 ? CMD_REMOVE : CMD_READ, big_page, $urandom_range(near));
			if ($urandom_range(4) == 0) begin
				r.linear_addr = VADDR_W'({$urandom, $urandom});
				r.entry_index = EIDX_W'($urandom);
			end
		end else begin
			r = blank_req(CMD_NONE, big_page);
		end
		return r;
	endfunction

	task automatic push_req(req_t r);
		todo_req.push_back(r);
		queued_cnt++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VADDR_W-1:0] val);
		@(negedge clk);
		while ($urandom_range(99) < IDLE_PCT) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_VIRT_BASE_SMALL: vbase[0] = val;
			REG_VIRT_BASE_LARGE: vbase[1] = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		do @(negedge clk); while (accepted_cnt != queued_cnt || pending_rsp.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic random_phase(logic [VADDR_W-1:0] va_small, logic [VADDR_W-1:0] va_large);
		write_reg(REG_VIRT_BASE_SMALL, va_small);
		write_reg(REG_VIRT_BASE_LARGE, va_large);
		@(posedge clk);
		repeat (RAND_ITEMS) push_req(random_req());
		drain();
	endtask

	// driver: hold a request until taken, then advance or idle
	always @(negedge clk) begin
		if (!start || req_taken) begin
			if (todo_req.size() != 0 &&
				!(!(issued_cnt >= 180 && issued_cnt < 260) && $urandom_range(99) < IDLE_PCT)) begin
				req <= todo_req.pop_front();
				start <= 1'b1;
				issued_cnt++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check results, predict accepted requests, watch for a hang
	always @(posedge clk) begin
		rsp_t want;
		if (done === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				$error("result with no request outstanding");
				mismatch_cnt++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.virt_addr !== want.virt_addr) begin
					$error("virt_addr: expected %h, got %h", want.virt_addr, rsp.virt_addr);
					mismatch_cnt++;
				end
				if (rsp.entry_value !== want.entry_value) begin
					$error("entry_value: expected %h, got %h", want.entry_value, rsp.entry_value);
					mismatch_cnt++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					mismatch_cnt++;
				end
			end
		end
		if (start && busy === 1'b0) begin
			pending_rsp.push_back(apply_request(req));
			accepted_cnt++;
		end
		req_taken <= start && busy === 1'b0;
		if (done === 1'b1 || (start && busy === 1'b0) || (cfg_valid && cfg_ready === 1'b1))
			stall_cnt = 0;
		else
			stall_cnt++;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		for (int t = 0; t < 2; t++) begin
			for (int i = 0; i < NENT; i++) leaf_tbl[t][i] = '0;
			bump_idx[t] = 0;
			vbase[t] = '0;
		end
		halted_pred = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_VIRT_BASE_SMALL, '0);
		write_reg(REG_VIRT_BASE_LARGE, '0);
		write_reg(REG_SPARE_A, VADDR_W'({$urandom, $urandom}));
		write_reg(REG_SPARE_B, VA_MAX);
		@(posedge clk);
		push_req(entry_req(CMD_READ, 1'b0, 0));
		push_req(map_req(PADDR_W'(52'h12345_6789A000), '0, 1'b0, 1'b1, 1'b1));
		push_req(map_req(PADDR_W'(52'h00000_00000123), '0, 1'b0, 1'b1, 1'b1));
		push_req(map_req(PA_MAX, SIZE_W'(1), 1'b0, 1'b1, 1'b0));
		push_req(map_req(PA_MAX, SIZE_W'(PSZ_LARGE), 1'b1, 1'b0, 1'b0));
		push_req(map_req(PADDR_W'(52'hABCDE_00000000), SIZE_W'(3 * PSZ_LARGE + 1), 1'b1,
			1'b1, 1'b1));
		push_req(map_req('0, SIZE_MAX, 1'b0, 1'b1, 1'b1));
		push_req(map_req('0, SIZE_MAX, 1'b1, 1'b1, 1'b1));
		for (int i = 0; i < 4; i++) push_req(entry_req(CMD_READ, 1'b0, i));
		push_req(entry_req(CMD_READ, 1'b1, 0));
		push_req(entry_req(CMD_READ, 1'b1, 1));
		push_req(entry_req(CMD_READ, 1'b1, 5));
		push_req(entry_req(CMD_READ, 1'b0, NENT - 1));
		push_req(entry_req(CMD_REMOVE, 1'b0, 1));
		push_req(entry_req(CMD_READ, 1'b0, 1));
		push_req(entry_req(CMD_REMOVE, 1'b1, NENT - 1));
		push_req(entry_req(CMD_REMOVE, 1'b1, 0));
		push_req(entry_req(CMD_READ, 1'b1, 0));
		push_req(blank_req(CMD_NONE, 1'($urandom)));
		push_req(map_req(PADDR_W'(52'hFEDCB_A9876000), SIZE_W'(PSZ_SMALL), 1'b0, 1'b0, 1'b1));
		push_req(entry_req(CMD_READ, 1'b0, 3));
		drain();

		random_phase('0, '0);
		random_phase(VA_MAX, VA_MAX);
		random_phase(VADDR_W'({$urandom, $urandom}), VADDR_W'({$urandom, $urandom}));
		random_phase(VADDR_W'({$urandom, $urandom}), VA_MAX - VADDR_W'($urandom));

		// fill both tables to the last entry, then overflow by one page
		@(posedge clk);
		push_req(map_req(PADDR_W'({$urandom, $urandom}) & ~PADDR_W'(PSZ_SMALL - 1),
			SIZE_W'((NENT - bump_idx[0]) * PSZ_SMALL), 1'b0, 1'b1, 1'b0));
		push_req(map_req(PADDR_W'({$urandom, $urandom}) & ~PADDR_W'(PSZ_LARGE - 1),
			SIZE_W'((NENT - bump_idx[1]) * PSZ_LARGE), 1'b1, 1'b0, 1'b1));
		push_req(map_req('0, SIZE_W'(1), 1'b0, 1'b1, 1'b1));
		push_req(map_req('0, SIZE_W'(1), 1'b1, 1'b1, 1'b1));
		push_req(entry_req(CMD_READ, 1'b0, NENT - 1));
		push_req(entry_req(CMD_READ, 1'b1, NENT - 1));
		drain();

		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
